### hdl/lsa_pkg.sv
// ============================================================================
// lsa_pkg
// Shared types, widths, register indexes and constants of the linkage servo
// angle unit.
// ============================================================================
package lsa_pkg;

   // Field and port widths.
   localparam int LEN_W      = 12;
   localparam int VAL_W      = 16;
   localparam int SERVO_W    = 8;
   localparam int KIND_W     = 2;
   localparam int ANG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_REGS   = 8;
   localparam int REQ_DATA_W = SERVO_W + VAL_W;
   localparam int RSP_DATA_W = SERVO_W + ANG_W;

   // Internal datapath widths.
   localparam int P_W      = 28;   // law-of-cosines numerator and atan x term
   localparam int DEN_W    = 27;   // gripper denominator 4*c*d
   localparam int YB_W     = 25;   // elbow term 2*c*o
   localparam int ROOT_W   = 27;   // square root result
   localparam int SQ_ARG_W = 2 * ROOT_W;
   localparam int REM_W    = ROOT_W + 3;
   localparam int V_W      = 45;   // CORDIC vector components
   localparam int Z_W      = 28;   // angle in 1/65536 degree
   localparam int OUT_FRAC = 10;   // 1/65536 degree down to 1/64 degree
   localparam int ANG_FULL_W = Z_W - OUT_FRAC;

   // Vector normalization: scale until one magnitude reaches 2**NORM_EXP.
   localparam int NORM_EXP    = 40;
   localparam int NORM_STAGES = 6;

   // CORDIC step count and the size of the arctangent table.
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_MAX       = 24;

   // Joint codes.
   typedef enum logic [KIND_W-1:0] {
      KIND_GRIP  = 2'd0,
      KIND_WRIST = 2'd1,
      KIND_ELBOW = 2'd2
   } kind_type;

   localparam logic [SERVO_W-1:0] SERVO_NONE = 8'hFF;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FINGER      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRIP_CRANK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRIP_ROD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GRIP_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GRIP_HIGH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ELBOW_CRANK = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ELBOW_ROD   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ELBOW_OFS   = 3'd7;
   localparam logic [LEN_W-1:0]     GRIP_HIGH_RESET = 12'd4095;

   // Joint limits.
   localparam logic signed [VAL_W-1:0] WRIST_LOW  = -16'sd11520;
   localparam logic signed [VAL_W-1:0] WRIST_HIGH = 16'sd11520;
   localparam logic signed [VAL_W-1:0] ELBOW_LOW  = 16'sd0;
   localparam logic signed [VAL_W-1:0] ELBOW_HIGH = 16'sd4095;

   // Angle constants in 1/65536 degree, output limits in 1/64 degree.
   localparam logic signed [Z_W-1:0] DEG90      = 28'sd5898240;
   localparam logic signed [Z_W-1:0] DEG180     = 28'sd11796480;
   localparam logic signed [Z_W-1:0] ROUND_HALF = 28'sd512;
   localparam logic signed [ANG_FULL_W-1:0] ANG_MIN = -18'sd5760;
   localparam logic signed [ANG_FULL_W-1:0] ANG_MAX = 18'sd23040;

   // Control tag that rides along with every item.
   typedef struct packed {
      logic                      valid;
      logic [SERVO_W-1:0]        servo;
      kind_type                  kind;
      logic                      err;
      logic signed [VAL_W-1:0]   wrist;
   } tag_type;

   // Payload of the square root chain.
   typedef struct packed {
      tag_type                   tag;
      logic signed [P_W-1:0]     xv;
      logic [YB_W-1:0]           yb;
      logic [SQ_ARG_W-1:0]       arg;
      logic [REM_W-1:0]          rem;
      logic [ROOT_W-1:0]         root;
   } sq_type;

   // Payload of the normalization and CORDIC chains.
   typedef struct packed {
      tag_type                   tag;
      logic signed [V_W-1:0]     x;
      logic signed [V_W-1:0]     y;
      logic signed [Z_W-1:0]     z;
   } cv_type;

   // Arctangent of 2**-i in 1/65536 degree.
   function automatic logic signed [Z_W-1:0] atan_step(input int i);
      logic signed [Z_W-1:0] v;
      case (i)
         0:       v = 28'sd2949120;
         1:       v = 28'sd1740967;
         2:       v = 28'sd919879;
         3:       v = 28'sd466945;
         4:       v = 28'sd234379;
         5:       v = 28'sd117304;
         6:       v = 28'sd58666;
         7:       v = 28'sd29335;
         8:       v = 28'sd14668;
         9:       v = 28'sd7334;
         10:      v = 28'sd3667;
         11:      v = 28'sd1833;
         12:      v = 28'sd917;
         13:      v = 28'sd458;
         14:      v = 28'sd229;
         15:      v = 28'sd115;
         16:      v = 28'sd57;
         17:      v = 28'sd29;
         18:      v = 28'sd14;
         19:      v = 28'sd7;
         20:      v = 28'sd4;
         21:      v = 28'sd2;
         22:      v = 28'sd1;
         default: v = 28'sd0;
      endcase
      return v;
   endfunction

endpackage

### hdl/lsa_sqrt_cell.sv
// ============================================================================
// lsa_sqrt_cell
// One digit of a restoring integer square root; the chain of these cells
// produces one root bit per cell and per clock while en is high.
// ============================================================================
module lsa_sqrt_cell #(
   parameter int BIT = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  lsa_pkg::sq_type d_in,
   output lsa_pkg::sq_type q_out
);
   import lsa_pkg::*;

   sq_type            q_ff;
   sq_type            q_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   // Bring down the next two argument bits and try the digit one.
   always_comb begin
      rem_sh = {d_in.rem[REM_W-3:0], d_in.arg[2*BIT+1 -: 2]};
      trial  = {1'b0, d_in.root, 2'b01};
      q_in   = d_in;
      if (rem_sh >= trial) begin
         q_in.rem  = rem_sh - trial;
         q_in.root = {d_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         q_in.rem  = rem_sh;
         q_in.root = {d_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_ff.tag.valid <= 1'b0;
      else if (en) q_ff <= q_in;
   end

   assign q_out = q_ff;

endmodule

### hdl/lsa_norm_cell.sv
// ============================================================================
// lsa_norm_cell
// One step of the vector normalizer: scales both components up by a fixed
// power of two when both stay below twice the normalization bound afterwards.
// ============================================================================
module lsa_norm_cell #(
   parameter int SHIFT = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  lsa_pkg::cv_type d_in,
   output lsa_pkg::cv_type q_out
);
   import lsa_pkg::*;

   localparam logic [V_W-1:0] LIMIT = V_W'(1) << (NORM_EXP + 1 - SHIFT);

   cv_type          q_ff;
   cv_type          q_in;
   logic [V_W-1:0]  ax;
   logic [V_W-1:0]  ay;

   // Shift when neither magnitude would reach twice the bound.
   always_comb begin
      ax   = d_in.x[V_W-1] ? unsigned'(-d_in.x) : unsigned'(d_in.x);
      ay   = d_in.y[V_W-1] ? unsigned'(-d_in.y) : unsigned'(d_in.y);
      q_in = d_in;
      if (ax < LIMIT && ay < LIMIT) begin
         q_in.x = d_in.x <<< SHIFT;
         q_in.y = d_in.y <<< SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_ff.tag.valid <= 1'b0;
      else if (en) q_ff <= q_in;
   end

   assign q_out = q_ff;

endmodule

### hdl/lsa_cordic_cell.sv
// ============================================================================
// lsa_cordic_cell
// One vectoring CORDIC rotation: turns the vector toward the x axis and
// accumulates the rotation angle.
// ============================================================================
module lsa_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  lsa_pkg::cv_type d_in,
   output lsa_pkg::cv_type q_out
);
   import lsa_pkg::*;

   localparam logic signed [Z_W-1:0] ATAN = atan_step(STEP);

   cv_type q_ff;
   cv_type q_in;

   // A vector already on the axis passes unchanged through the rest.
   always_comb begin
      q_in = d_in;
      if (!d_in.y[V_W-1] && d_in.y != '0) begin
         q_in.x = d_in.x + (d_in.y >>> STEP);
         q_in.y = d_in.y - (d_in.x >>> STEP);
         q_in.z = d_in.z + ATAN;
      end else if (d_in.y[V_W-1]) begin
         q_in.x = d_in.x - (d_in.y >>> STEP);
         q_in.y = d_in.y + (d_in.x >>> STEP);
         q_in.z = d_in.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_ff.tag.valid <= 1'b0;
      else if (en) q_ff <= q_in;
   end

   assign q_out = q_ff;

endmodule

### hdl/linkage_servo_angle_unit.sv
// ============================================================================
// linkage_servo_angle_unit
// Converts joint commands into servo target angles through the gripper and
// elbow crank-rod linkages, fully pipelined.
// ============================================================================
// The unit takes one request item per clock while req_tready is high. The
// chain holds five stages of clamping, products and sums, one square root
// cell per root bit (27), one stage of quadrant folding, six normalizer
// cells, one CORDIC cell per step, one stage of rounding and the output
// register. A skid register behind the output keeps the pipeline moving
// while a result waits; req_tready drops only while that skid register is
// full. Requests for servo 255 or for joint code 3 are accepted and give
// no result. Configuration writes are always ready and take effect at once;
// they belong to times when no item is in flight.
// ============================================================================
module linkage_servo_angle_unit #(
   parameter int CORDIC_STEPS = lsa_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration writes.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lsa_pkg::LEN_W-1:0]         csr_data,
   // Requests.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lsa_pkg::REQ_DATA_W-1:0]    req_tdata,  // servo_index, joint_value
   input  logic [lsa_pkg::KIND_W-1:0]        req_tuser,  // req_type
   // Results.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lsa_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // target_servo, target_angle
   output logic [0:0]                        rsp_tuser   // math_error
);
   import lsa_pkg::*;

   localparam int PROD_W = 2 * LEN_W;
   localparam int CQ_W   = 2 * LEN_W + 1;
   localparam int QQ_W   = 2 * LEN_W + 2;
   localparam int GS_W   = VAL_W + 2;

   typedef struct packed {
      tag_type              tag;
      logic [LEN_W-1:0]     c;
      logic [LEN_W-1:0]     r;
      logic [LEN_W-1:0]     o;
      logic [LEN_W:0]       q;
   } a_type;

   typedef struct packed {
      tag_type              tag;
      logic                 cz;
      logic [PROD_W-1:0]    cc;
      logic [PROD_W-1:0]    rr;
      logic [PROD_W-1:0]    oo;
      logic [QQ_W-1:0]      qq;
      logic [CQ_W-1:0]      cq;
      logic [PROD_W-1:0]    co;
   } b_type;

   typedef struct packed {
      tag_type              tag;
      logic signed [P_W-1:0] p;
      logic [DEN_W-1:0]     den;
      logic [PROD_W-1:0]    cc;
      logic [YB_W-1:0]      s;
      logic signed [P_W-1:0] xv;
      logic [YB_W-1:0]      yb;
   } c_type;

   typedef struct packed {
      tag_type              tag;
      logic signed [P_W-1:0] xv;
      logic [YB_W-1:0]      yb;
      logic [SQ_ARG_W-1:0]  m1;
      logic [SQ_ARG_W-1:0]  m2;
   } d_type;

   typedef struct packed {
      logic [SERVO_W-1:0]      servo;
      logic signed [ANG_W-1:0] angle;
      logic                    err;
   } res_type;

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic [LEN_W-1:0] cfg_ff [NUM_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++)
            cfg_ff[i] <= (i == int'(REG_GRIP_HIGH)) ? GRIP_HIGH_RESET : LEN_W'(0);
      end else if (csr_valid && csr_ready) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline advance and input unpacking.
   // ------------------------------------------------------------------------
   logic                     pipe_en;
   logic                     accept;
   logic                     skid_valid_ff, skid_valid_in;
   logic [SERVO_W-1:0]       in_servo;
   logic signed [VAL_W-1:0]  in_val;

   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;
   assign accept     = req_tvalid && req_tready;
   assign in_servo   = req_tdata[SERVO_W-1:0];
   assign in_val     = signed'(req_tdata[REQ_DATA_W-1:SERVO_W]);

   // ------------------------------------------------------------------------
   // Stage A: clamp the command and pick the linkage lengths.
   // ------------------------------------------------------------------------
   a_type                    a_ff, a_in;
   logic signed [GS_W-1:0]   gsum;
   logic [LEN_W:0]           glo, ghi, grip_dist;
   logic [LEN_W-1:0]         slide;
   logic signed [VAL_W-1:0]  wrist;
   logic                     grip_in;

   assign gsum = $signed({{2{in_val[VAL_W-1]}}, in_val})
               + $signed({5'b0, cfg_ff[REG_FINGER], 1'b0});
   assign glo  = {cfg_ff[REG_GRIP_LOW], 1'b0};
   assign ghi  = {cfg_ff[REG_GRIP_HIGH], 1'b0};
   assign grip_in = (req_tuser == KIND_GRIP);

   always_comb begin
      if (gsum < $signed({5'b0, glo}))      grip_dist = glo;
      else if (gsum > $signed({5'b0, ghi})) grip_dist = ghi;
      else                                  grip_dist = gsum[LEN_W:0];

      if (in_val < ELBOW_LOW)       slide = LEN_W'(ELBOW_LOW);
      else if (in_val > ELBOW_HIGH) slide = LEN_W'(ELBOW_HIGH);
      else                          slide = in_val[LEN_W-1:0];

      if (in_val < WRIST_LOW)       wrist = WRIST_LOW;
      else if (in_val > WRIST_HIGH) wrist = WRIST_HIGH;
      else                          wrist = in_val;

      a_in.tag.valid = accept && (in_servo != SERVO_NONE)
                       && (req_tuser == KIND_GRIP || req_tuser == KIND_WRIST
                           || req_tuser == KIND_ELBOW);
      a_in.tag.servo = in_servo;
      a_in.tag.kind  = kind_type'(req_tuser);
      a_in.tag.err   = 1'b0;
      a_in.tag.wrist = wrist;
      a_in.c = grip_in ? cfg_ff[REG_GRIP_CRANK] : cfg_ff[REG_ELBOW_CRANK];
      a_in.r = grip_in ? cfg_ff[REG_GRIP_ROD] : cfg_ff[REG_ELBOW_ROD];
      a_in.o = cfg_ff[REG_ELBOW_OFS];
      a_in.q = grip_in ? grip_dist : {1'b0, slide};
   end

   always_ff @(posedge clock) begin
      if (reset) a_ff.tag.valid <= 1'b0;
      else if (pipe_en) a_ff <= a_in;
   end

   // ------------------------------------------------------------------------
   // Stage B: squares and cross products of the lengths.
   // ------------------------------------------------------------------------
   b_type b_ff, b_in;

   always_comb begin
      b_in.tag = a_ff.tag;
      b_in.cz  = (a_ff.c == '0);
      b_in.cc  = a_ff.c * a_ff.c;
      b_in.rr  = a_ff.r * a_ff.r;
      b_in.oo  = a_ff.o * a_ff.o;
      b_in.qq  = a_ff.q * a_ff.q;
      b_in.cq  = a_ff.c * a_ff.q;
      b_in.co  = a_ff.c * a_ff.o;
   end

   always_ff @(posedge clock) begin
      if (reset) b_ff.tag.valid <= 1'b0;
      else if (pipe_en) b_ff <= b_in;
   end

   // ------------------------------------------------------------------------
   // Stage C: law-of-cosines terms (gripper) or crank-rod terms (elbow).
   // ------------------------------------------------------------------------
   c_type                  c_ff, c_in;
   logic signed [P_W-1:0]  g_num, e_n, e_x;
   logic [DEN_W-1:0]       g_den;
   logic                   grip_c;

   assign grip_c = (b_ff.tag.kind == KIND_GRIP);
   assign g_num = $signed({2'b0, b_ff.cc, 2'b0}) - $signed({2'b0, b_ff.rr, 2'b0})
                + $signed({2'b0, b_ff.qq});
   assign g_den = {b_ff.cq, 2'b0};
   assign e_n   = $signed({4'b0, b_ff.cc}) - $signed({4'b0, b_ff.rr})
                + $signed({4'b0, b_ff.oo}) + $signed({2'b0, b_ff.qq});
   assign e_x   = $signed({2'b0, b_ff.cq, 1'b0}) + e_n;

   always_comb begin
      c_in.tag = b_ff.tag;
      c_in.p   = grip_c ? g_num : e_n;
      c_in.den = g_den;
      c_in.cc  = b_ff.cc;
      c_in.s   = YB_W'(b_ff.oo) + YB_W'(b_ff.qq);
      c_in.xv  = grip_c ? g_num : e_x;
      c_in.yb  = grip_c ? '0 : {b_ff.co, 1'b0};
      // The wrist never faults; only the linkage joints check their terms.
      if (grip_c)                           c_in.tag.err = (g_den == '0);
      else if (b_ff.tag.kind == KIND_ELBOW) c_in.tag.err = b_ff.cz || (e_x == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) c_ff.tag.valid <= 1'b0;
      else if (pipe_en) c_ff <= c_in;
   end

   // ------------------------------------------------------------------------
   // Stage D: the two wide products under the square root.
   // ------------------------------------------------------------------------
   d_type                 d_ff, d_in;
   logic [P_W-1:0]        p_abs;
   logic [DEN_W-1:0]      pm, mul_a, mul_b;
   logic                  grip_d;

   assign grip_d = (c_ff.tag.kind == KIND_GRIP);
   assign p_abs  = c_ff.p[P_W-1] ? unsigned'(-c_ff.p) : unsigned'(c_ff.p);
   assign pm     = p_abs[DEN_W-1:0];
   assign mul_a  = grip_d ? c_ff.den : DEN_W'(c_ff.cc);
   assign mul_b  = grip_d ? c_ff.den : DEN_W'(c_ff.s);

   always_comb begin
      d_in.tag = c_ff.tag;
      d_in.xv  = c_ff.xv;
      d_in.yb  = c_ff.yb;
      d_in.m1  = mul_a * mul_b;
      d_in.m2  = pm * pm;
      // The arccosine argument leaves [-1, 1] when the numerator passes den.
      if (grip_d && p_abs > P_W'(c_ff.den)) d_in.tag.err = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) d_ff.tag.valid <= 1'b0;
      else if (pipe_en) d_ff <= d_in;
   end

   // ------------------------------------------------------------------------
   // Stage E: the radicand, and a negative elbow radicand is an error.
   // ------------------------------------------------------------------------
   sq_type                       e_ff, e_in;
   logic signed [SQ_ARG_W+1:0]   e_ra;

   assign e_ra = $signed({d_ff.m1, 2'b0}) - $signed({2'b0, d_ff.m2});

   always_comb begin
      e_in.tag  = d_ff.tag;
      e_in.xv   = d_ff.xv;
      e_in.yb   = d_ff.yb;
      e_in.rem  = '0;
      e_in.root = '0;
      if (d_ff.tag.kind == KIND_GRIP) begin
         e_in.arg = d_ff.m1 - d_ff.m2;
      end else begin
         e_in.arg = e_ra[SQ_ARG_W-1:0];
         if (d_ff.tag.kind == KIND_ELBOW && e_ra[SQ_ARG_W+1]) e_in.tag.err = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) e_ff.tag.valid <= 1'b0;
      else if (pipe_en) e_ff <= e_in;
   end

   // ------------------------------------------------------------------------
   // Square root chain, one root bit per cell.
   // ------------------------------------------------------------------------
   sq_type sq_chain [ROOT_W+1];

   assign sq_chain[0] = e_ff;

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      lsa_sqrt_cell #(.BIT(ROOT_W - 1 - g)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (pipe_en),
         .d_in  (sq_chain[g]),
         .q_out (sq_chain[g+1])
      );
   end

   // ------------------------------------------------------------------------
   // Stage F: form the vector and fold it into the right half plane.
   // ------------------------------------------------------------------------
   cv_type                 f_ff, f_in;
   sq_type                 sq_end;
   logic [P_W-1:0]         y_sum;
   logic signed [V_W-1:0]  fx, fy, ft;

   assign sq_end = sq_chain[ROOT_W];
   assign y_sum  = P_W'(sq_end.yb) + P_W'(sq_end.root);

   always_comb begin
      fx = {{(V_W-P_W){sq_end.xv[P_W-1]}}, sq_end.xv};
      fy = signed'({{(V_W-P_W){1'b0}}, y_sum});
      ft = fx;
      f_in.tag = sq_end.tag;
      f_in.z   = '0;
      // The elbow keeps x positive by turning the whole vector around.
      if (sq_end.tag.kind == KIND_ELBOW && fx[V_W-1]) begin
         fx = -fx;
         fy = -fy;
         ft = fx;
      end
      // A vector in the left half plane is turned by a quarter turn first.
      if (fx[V_W-1]) begin
         if (!fy[V_W-1]) begin
            fx = fy;
            fy = -ft;
            f_in.z = DEG90;
         end else begin
            fx = -fy;
            fy = ft;
            f_in.z = -DEG90;
         end
      end
      f_in.x = fx;
      f_in.y = fy;
   end

   always_ff @(posedge clock) begin
      if (reset) f_ff.tag.valid <= 1'b0;
      else if (pipe_en) f_ff <= f_in;
   end

   // ------------------------------------------------------------------------
   // Normalizer chain, then the CORDIC chain.
   // ------------------------------------------------------------------------
   cv_type norm_chain [NORM_STAGES+1];
   cv_type rot_chain  [CORDIC_STEPS+1];

   assign norm_chain[0] = f_ff;

   for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
      lsa_norm_cell #(.SHIFT(1 << (NORM_STAGES - 1 - g))) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (pipe_en),
         .d_in  (norm_chain[g]),
         .q_out (norm_chain[g+1])
      );
   end

   assign rot_chain[0] = norm_chain[NORM_STAGES];

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
      lsa_cordic_cell #(.STEP(g)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (pipe_en),
         .d_in  (rot_chain[g]),
         .q_out (rot_chain[g+1])
      );
   end

   // ------------------------------------------------------------------------
   // Stage G: servo angle, rounded to 1/64 degree and limited.
   // ------------------------------------------------------------------------
   cv_type                         rot_end;
   res_type                        g_ff, g_in;
   logic                           g_valid_ff;
   logic signed [Z_W-1:0]          fine, fine_rnd;
   logic signed [ANG_FULL_W-1:0]   ang_full, ang_lim;

   assign rot_end  = rot_chain[CORDIC_STEPS];
   assign fine     = (rot_end.tag.kind == KIND_GRIP) ? (DEG90 - rot_end.z)
                                                     : (DEG180 - (rot_end.z <<< 1));
   assign fine_rnd = fine + ROUND_HALF;
   assign ang_full = fine_rnd[Z_W-1:OUT_FRAC];

   always_comb begin
      if (ang_full < ANG_MIN)      ang_lim = ANG_MIN;
      else if (ang_full > ANG_MAX) ang_lim = ANG_MAX;
      else                         ang_lim = ang_full;

      g_in.servo = rot_end.tag.servo;
      g_in.err   = rot_end.tag.err;
      if (rot_end.tag.kind == KIND_WRIST) g_in.angle = rot_end.tag.wrist;
      else if (rot_end.tag.err)           g_in.angle = '0;
      else                                g_in.angle = ANG_W'(ang_lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         g_ff       <= g_in;
         g_valid_ff <= rot_end.tag.valid;
      end
   end

   // ------------------------------------------------------------------------
   // Output register with a skid register behind it.
   // ------------------------------------------------------------------------
   res_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (g_valid_ff) begin
         if (!out_valid_ff || rsp_tready) begin
            out_in       = g_ff;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = g_ff;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.angle, out_ff.servo};
   assign rsp_tuser  = out_ff.err;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // The skid register only holds an item while the output register is full.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // The skid register fills only when the output was stalled.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid register filled without a stalled output");

   // A result flagged with a math error carries a zero angle.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[RSP_DATA_W-1:SERVO_W] == '0))
      else $error("math error result with a nonzero angle");

   // Unassigned servos never produce a result.
   a_no_unassigned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[SERVO_W-1:0] != SERVO_NONE))
      else $error("result for an unassigned servo");

endmodule

### test/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the linkage servo angle unit. A table of directed
// requests runs at reset settings. Several register settings follow, each
// with a phase of random requests. Directed rows are checked against their
// table entries; random ones against a bit-exact model of the linkage math.
// ============================================================================
module testbench;
   import lsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASE_ITEMS  = 280;
   localparam int HOLD_AT_ITEM = 500;
   localparam int HOLD_CYCLES  = 400;
   localparam int CALM_LO      = 800;
   localparam int CALM_HI      = 1100;
   localparam longint ONE_DEG  = 65536;
   localparam longint NORM_TOP = 64'sd1 << 40;

   typedef struct {
      logic [SERVO_W-1:0]      servo;
      logic signed [ANG_W-1:0] angle;
      logic                    err;
   } angle_result_type;

   typedef struct {
      logic [KIND_W-1:0]       kind;
      logic [SERVO_W-1:0]      servo;
      logic signed [VAL_W-1:0] value;
      bit                      typed;
      logic signed [ANG_W-1:0] angle;
      logic                    err;
   } joint_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LEN_W-1:0] csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   longint cfg_reg [NUM_REGS];
   angle_result_type pending_angles[$];
   int cycle_count = 0;
   int mismatch_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int error_results = 0;

   linkage_servo_angle_unit dut (.*);

   always #5 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("linkage_servo_angle_unit: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("[%0d] %s", cycle_count, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Linkage arithmetic.
   // ---------------------------------------------------------------------
   function automatic longint root_floor(input longint unsigned n);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint atan_entry(input int i);
      longint tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                           58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                           229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      return tab[i];
   endfunction

   // Angle of the vector (x, y) in 1/65536 degree by CORDIC vectoring.
   function automatic longint vector_angle(input longint y, input longint x);
      longint z, t, nx, ny;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 90 * ONE_DEG;
         end else begin
            t = x; x = -y; y = t; z = -90 * ONE_DEG;
         end
      end
      if (x == 0 && y == 0) return z;
      while ((x < 0 ? -x : x) < NORM_TOP && (y < 0 ? -y : y) < NORM_TOP) begin
         x *= 2;
         y *= 2;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         if (y == 0) break;
         if (y > 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += atan_entry(i);
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= atan_entry(i);
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   function automatic longint round_angle(input longint fine);
      longint a;
      a = (fine + 512) >>> 10;
      if (a < -5760) a = -5760;
      if (a > 23040) a = 23040;
      return a;
   endfunction

   function automatic longint limit_to(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Returns 0 when the request gives no result.
   function automatic bit servo_angle_for(input logic [KIND_W-1:0] kind,
                                          input logic [SERVO_W-1:0] servo,
                                          input logic signed [VAL_W-1:0] value,
                                          output angle_result_type res);
      longint v, angle, c, r, o, d, num, den, len, n, root_arg, x, y;
      bit err;
      v = longint'(value);
      angle = 0;
      err = 0;
      res = '{servo: servo, angle: '0, err: 1'b0};
      if (servo == SERVO_NONE || kind == KIND_SPARE) return 0;
      if (kind == KIND_GRIP) begin
         c = cfg_reg[REG_GRIP_CRANK];
         r = cfg_reg[REG_GRIP_ROD];
         d = limit_to(v + 2 * cfg_reg[REG_FINGER], 2 * cfg_reg[REG_GRIP_LOW],
                      2 * cfg_reg[REG_GRIP_HIGH]);
         num = 4 * (c * c - r * r) + d * d;
         den = 4 * c * d;
         if (den <= 0 || (num < 0 ? -num : num) > den) err = 1;
         else angle = round_angle(90 * ONE_DEG
                      - vector_angle(root_floor(den * den - num * num), num));
      end else if (kind == KIND_WRIST) begin
         angle = limit_to(v, WRIST_LOW, WRIST_HIGH);
      end else begin
         c = cfg_reg[REG_ELBOW_CRANK];
         r = cfg_reg[REG_ELBOW_ROD];
         o = cfg_reg[REG_ELBOW_OFS];
         len = limit_to(v, ELBOW_LOW, ELBOW_HIGH);
         n = c * c - r * r + o * o + len * len;
         root_arg = 4 * c * c * (o * o + len * len) - n * n;
         if (c == 0 || root_arg < 0) begin
            err = 1;
         end else begin
            y = 2 * c * o + root_floor(root_arg);
            x = 2 * c * len + n;
            if (x == 0) begin
               err = 1;
            end else begin
               if (x < 0) begin
                  x = -x; y = -y;
               end
               angle = round_angle(180 * ONE_DEG - 2 * vector_angle(y, x));
            end
         end
      end
      if (err) angle = 0;
      res.angle = angle[ANG_W-1:0];
      res.err = err;
      return 1;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers.
   // ---------------------------------------------------------------------
   // A stretch of items during which neither side idles.
   function automatic bit calm_window();
      return items_sent >= CALM_LO && items_sent < CALM_HI;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      bit took;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[LEN_W-1:0];
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      cfg_reg[idx] = value & 12'hFFF;
   endtask

   task automatic write_all(input int f, input int gc, input int gr, input int lo,
                            input int hi, input int ec, input int er, input int eo);
      write_reg(REG_FINGER, f);
      write_reg(REG_GRIP_CRANK, gc);
      write_reg(REG_GRIP_ROD, gr);
      write_reg(REG_GRIP_LOW, lo);
      write_reg(REG_GRIP_HIGH, hi);
      write_reg(REG_ELBOW_CRANK, ec);
      write_reg(REG_ELBOW_ROD, er);
      write_reg(REG_ELBOW_OFS, eo);
      csr_valid <= 1'b0;
   endtask

   task automatic write_nominal();
      int gc;
      gc = $urandom_range(100, 1500);
      write_all($urandom_range(0, 400), gc, gc + $urandom_range(0, 1500),
                $urandom_range(0, 500), $urandom_range(1500, 4095),
                $urandom_range(100, 2000), $urandom_range(100, 3000),
                $urandom_range(0, 1000));
   endtask

   // Offers one item; the expectation goes in when it is accepted.
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SERVO_W-1:0] servo,
                               input logic signed [VAL_W-1:0] value, input bit use_typed,
                               input angle_result_type typed_res);
      angle_result_type res;
      bit gives, took;
      if (!calm_window() && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      gives = servo_angle_for(kind, servo, value, res);
      if (use_typed) res = typed_res;
      req_tvalid <= 1'b1;
      req_tdata <= {value, servo};
      req_tuser <= kind;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      items_sent++;
      if (gives) pending_angles.push_back(res);
   endtask

   // Waits out every expected result plus the items still in the pipe.
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random idling, one long hold-off, and result checking.
   // ---------------------------------------------------------------------
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm_window() || ($urandom_range(99) >= 15);
         end
      end
   end

   always @(negedge clock) begin
      angle_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser[0]) error_results++;
         if (pending_angles.size() == 0) begin
            report_mismatch($sformatf("unexpected result servo %0d", rsp_tdata[7:0]));
         end else begin
            want = pending_angles.pop_front();
            if (rsp_tdata[SERVO_W-1:0] !== want.servo)
               report_mismatch($sformatf("servo %0d, want %0d",
                               rsp_tdata[SERVO_W-1:0], want.servo));
            if (rsp_tdata[SERVO_W +: ANG_W] !== want.angle)
               report_mismatch($sformatf("angle %0d, want %0d",
                               $signed(rsp_tdata[SERVO_W +: ANG_W]), want.angle));
            if (rsp_tuser[0] !== want.err)
               report_mismatch($sformatf("error flag %0b, want %0b", rsp_tuser[0], want.err));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      joint_row_type joint_rows [12];
      angle_result_type typed;
      logic [KIND_W-1:0] kind;
      logic [SERVO_W-1:0] servo;
      logic signed [VAL_W-1:0] value;
      int h;

      // At reset both crank lengths are zero, so linkage joints fault.
      joint_rows = '{
         '{KIND_WRIST, 8'd0,   -16'sd32768, 1, -16'sd11520, 1'b0},
         '{KIND_WRIST, 8'd254,  16'sd32767, 1,  16'sd11520, 1'b0},
         '{KIND_WRIST, 8'd17,  -16'sd11521, 1, -16'sd11520, 1'b0},
         '{KIND_WRIST, 8'd85,   16'sd0,     1,  16'sd0,     1'b0},
         '{KIND_WRIST, 8'd170,  16'sd11519, 1,  16'sd11519, 1'b0},
         '{KIND_GRIP,  8'd0,    16'sd0,     1,  16'sd0,     1'b1},
         '{KIND_GRIP,  8'd254,  16'sd32767, 1,  16'sd0,     1'b1},
         '{KIND_GRIP,  8'd3,   -16'sd32768, 1,  16'sd0,     1'b1},
         '{KIND_ELBOW, 8'd1,    16'sd0,     1,  16'sd0,     1'b1},
         '{KIND_ELBOW, 8'd200, -16'sd32768, 1,  16'sd0,     1'b1},
         '{KIND_WRIST, 8'd255,  16'sd100,   0,  16'sd0,     1'b0},
         '{KIND_SPARE, 8'd9,    16'sd100,   0,  16'sd0,     1'b0}
      };
      for (int i = 0; i < NUM_REGS; i++) cfg_reg[i] = 0;
      cfg_reg[REG_GRIP_HIGH] = GRIP_HIGH_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (joint_rows[i]) begin
         typed = '{servo: joint_rows[i].servo, angle: joint_rows[i].angle,
                   err: joint_rows[i].err};
         send_request(joint_rows[i].kind, joint_rows[i].servo, joint_rows[i].value,
                      joint_rows[i].typed, typed);
      end
      drain_pipe();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: write_all(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
            2: write_all(0, $urandom_range(1, 800), $urandom_range(800, 2000), 4095, 0,
                         0, $urandom_range(0, 4095), $urandom_range(0, 4095));
            default: write_nominal();
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 70) begin
               // Well-formed joint commands near the working range.
               kind = KIND_W'($urandom_range(0, 2));
               servo = SERVO_W'($urandom_range(0, 254));
               h = $urandom_range(0, 4000);
               case (kind)
                  KIND_GRIP:  value = VAL_W'(2 * h - 2 * cfg_reg[REG_FINGER]);
                  KIND_ELBOW: value = VAL_W'($urandom_range(0, 4300) - 100);
                  default:    value = VAL_W'($urandom_range(0, 24000) - 12000);
               endcase
            end else begin
               kind = KIND_W'($urandom_range(0, 3));
               servo = SERVO_W'($urandom_range(0, 255));
               value = VAL_W'($urandom());
            end
            send_request(kind, servo, value, 0, typed);
         end
         drain_pipe();
      end

      $display("sent %0d request items, checked %0d results (%0d with the error flag)",
               items_sent, results_seen, error_results);
      $display("covered reset, all-ones, crossed-limit and three random linkage settings");
      if (mismatch_count == 0) begin
         $display("linkage_servo_angle_unit: match");
      end else begin
         $display("linkage_servo_angle_unit: mismatch");
      end
      $finish;
   end

endmodule
